// File: sv/slr_pkg.sv
// shared types, constants and widths of the stereo linear resampler
package slr_pkg;

    localparam int K_SAMPLE_W       = 16;
    localparam int K_PHASE_W        = 18;
    localparam int K_RATE_W         = 18;
    localparam int K_MAX_OUT        = 6;
    localparam int K_OUTPUT_RATE_HZ = 48000;
    localparam int K_QUEUE_DEPTH    = 4;
    localparam int K_MAG_W          = 34;  // |cur - prev| * phase
    localparam int K_Q_W            = 16;  // quotient bits of one division
    localparam int K_PADDR_W        = 3;
    localparam int K_PDATA_W        = 32;

    // division by the output rate: 48000 = 375 << 7, the shift is free and
    // the division by 375 is a multiply by ceil(2^34 / 375) then a shift by 34;
    // exact for every dividend below 2^25 since 45812985 * 375 - 2^34 = 191 <= 2^9
    localparam int K_RATE_SHIFT  = 7;
    localparam int K_RECIP_W     = 26;
    localparam int K_RECIP_SHIFT = 34;
    localparam logic [K_RECIP_W-1:0] K_RECIP = K_RECIP_W'(45812985);

    localparam logic [K_RATE_W-1:0] K_RATE_RESET = K_RATE_W'(48000);

    // register index, taken from paddr[2]
    localparam logic K_REG_INPUT_RATE = 1'b0;

    typedef struct packed {
        logic signed [K_SAMPLE_W-1:0] left_in;
        logic signed [K_SAMPLE_W-1:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [K_SAMPLE_W-1:0] left_out;
        logic signed [K_SAMPLE_W-1:0] right_out;
        logic                         last_of_run;
    } t_out_item;

    // one output to compute: the two frames, the phase and the end-of-run flag
    typedef struct packed {
        logic signed [K_SAMPLE_W-1:0] prev_left;
        logic signed [K_SAMPLE_W-1:0] prev_right;
        logic signed [K_SAMPLE_W-1:0] cur_left;
        logic signed [K_SAMPLE_W-1:0] cur_right;
        logic        [K_PHASE_W-1:0]  phase;
        logic                         last;
    } t_job;

endpackage

// File: sv/slr_front.sv
// front end: accepts frames, steps the phase and issues one job per output
module slr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [slr_pkg::K_RATE_W-1:0]  i_rate,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  slr_pkg::t_in_item             i_in_item,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output slr_pkg::t_job                 o_q_job
);
    import slr_pkg::*;

    localparam logic [K_PHASE_W:0] K_OUT = (K_PHASE_W+1)'(K_OUTPUT_RATE_HZ);
    localparam logic [2:0] K_LAST_CNT = 3'(K_MAX_OUT - 1);

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_GEN  = 2'b10
    } t_front_state;

    t_front_state           r_state, n_state;
    logic [K_PHASE_W-1:0]   r_phase_acc, n_phase_acc;
    logic [K_PHASE_W-1:0]   r_phase, n_phase;
    logic [2:0]             r_cnt, n_cnt;
    t_in_item               r_prev, n_prev;
    t_in_item               r_cur, n_cur;

    logic [K_PHASE_W:0]     w_next;
    logic                   w_past_end;
    logic                   w_last;
    logic                   w_acc_past;

    assign w_next     = {1'b0, r_phase} + {1'b0, i_rate};
    assign w_past_end = (w_next >= K_OUT);
    assign w_last     = w_past_end || (r_cnt == K_LAST_CNT);
    assign w_acc_past = ({1'b0, r_phase_acc} >= K_OUT);

    assign o_in_ready = (r_state == FS_IDLE);

    always_comb begin
        n_state     = r_state;
        n_phase_acc = r_phase_acc;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_prev      = r_prev;
        n_cur       = r_cur;
        o_q_push    = 1'b0;
        o_q_job.prev_left  = r_prev.left_in;
        o_q_job.prev_right = r_prev.right_in;
        o_q_job.cur_left   = r_cur.left_in;
        o_q_job.cur_right  = r_cur.right_in;
        o_q_job.phase      = r_phase;
        o_q_job.last       = w_last;
        unique case (r_state)
            FS_IDLE: begin
                if (i_in_valid) begin
                    if (w_acc_past) begin
                        // decimation: frame makes no output
                        n_phase_acc = K_PHASE_W'({1'b0, r_phase_acc} - K_OUT);
                        n_prev      = i_in_item;
                    end else begin
                        n_cur   = i_in_item;
                        n_phase = r_phase_acc;
                        n_cnt   = '0;
                        n_state = FS_GEN;
                    end
                end
            end
            FS_GEN: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    if (w_last) begin
                        // a run cut short at the output limit restarts at phase zero
                        n_phase_acc = w_past_end ? K_PHASE_W'(w_next - K_OUT) : '0;
                        n_prev      = r_cur;
                        n_state     = FS_IDLE;
                    end else begin
                        n_phase = w_next[K_PHASE_W-1:0];
                        n_cnt   = r_cnt + 3'd1;
                    end
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_phase_acc <= '0;
            r_prev      <= '0;
        end else begin
            r_state     <= n_state;
            r_phase_acc <= n_phase_acc;
            r_prev      <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_cnt   <= n_cnt;
        r_cur   <= n_cur;
    end

endmodule

// File: sv/slr_queue.sv
// small job queue between the front end and the interpolation back end
module slr_queue #(
    parameter int DEPTH = slr_pkg::K_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slr_pkg::t_job i_wr_data,
    input  logic          i_pop,
    output slr_pkg::t_job o_rd_data,
    output logic          o_full,
    output logic          o_empty
);
    import slr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] K_PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] K_CNT_FULL = CNT_W'(DEPTH);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full    = (r_count == K_CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == K_PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == K_PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: sv/slr_back.sv
// back end: multiply, reciprocal division by the output rate, rounding, output register
module slr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  slr_pkg::t_job     i_q_job,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output slr_pkg::t_out_item o_out_item
);
    import slr_pkg::*;

    localparam int K_X_W    = K_MAG_W - K_RATE_SHIFT;
    localparam int K_PROD_W = K_X_W + K_RECIP_W;

    typedef enum logic [4:0] {
        BS_IDLE = 5'b00001,
        BS_MUL  = 5'b00010,
        BS_DIV  = 5'b00100,
        BS_REM  = 5'b01000,
        BS_FIN  = 5'b10000
    } t_back_state;

    // trunc toward zero of prev + sign * (q_mag + remainder / out_rate)
    function automatic logic [K_SAMPLE_W-1:0] fix_result(
        input logic [K_SAMPLE_W-1:0] prev,
        input logic [K_Q_W-1:0]      q_mag,
        input logic                  neg,
        input logic                  rem_nz
    );
        logic [K_SAMPLE_W+1:0] qz;
        logic [K_SAMPLE_W+1:0] qs;
        logic [K_SAMPLE_W+1:0] s;
        logic [K_SAMPLE_W+1:0] r;
        qz = {2'b00, q_mag};
        qs = neg ? ((K_SAMPLE_W+2)'(0) - (qz + (K_SAMPLE_W+2)'(rem_nz))) : qz;
        s  = {{2{prev[K_SAMPLE_W-1]}}, prev} + qs;
        r  = s + (K_SAMPLE_W+2)'(s[K_SAMPLE_W+1] & rem_nz);
        return r[K_SAMPLE_W-1:0];
    endfunction

    // magnitude of cur - prev, 16 bits unsigned, and its sign
    function automatic logic [K_SAMPLE_W:0] diff_mag(
        input logic [K_SAMPLE_W-1:0] prev,
        input logic [K_SAMPLE_W-1:0] cur
    );
        logic [K_SAMPLE_W:0] d;
        logic [K_SAMPLE_W:0] m;
        d = {cur[K_SAMPLE_W-1], cur} - {prev[K_SAMPLE_W-1], prev};
        m = d[K_SAMPLE_W] ? ((K_SAMPLE_W+1)'(0) - d) : d;
        return {d[K_SAMPLE_W], m[K_SAMPLE_W-1:0]};
    endfunction

    t_back_state            r_state, n_state;
    t_job                   r_job;
    logic [K_MAG_W-1:0]     r_prod_l, r_prod_r;
    logic [K_Q_W-1:0]       r_q_l, r_q_r;
    logic                   r_neg_l, r_neg_r;
    logic                   r_rem_nz_l, r_rem_nz_r;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic [K_SAMPLE_W:0]    w_dm_l, w_dm_r;
    logic [K_PROD_W-1:0]    w_recip_l, w_recip_r;
    logic [K_MAG_W-1:0]     w_qo_l, w_qo_r;
    logic                   w_load_out;

    assign w_dm_l = diff_mag(r_job.prev_left, r_job.cur_left);
    assign w_dm_r = diff_mag(r_job.prev_right, r_job.cur_right);

    // product is below 2^16 * 48000, so the shifted dividend stays below 2^25
    assign w_recip_l = K_PROD_W'(r_prod_l[K_MAG_W-1:K_RATE_SHIFT]) * K_PROD_W'(K_RECIP);
    assign w_recip_r = K_PROD_W'(r_prod_r[K_MAG_W-1:K_RATE_SHIFT]) * K_PROD_W'(K_RECIP);

    // quotient times the output rate, compared against the product for the remainder
    assign w_qo_l = K_MAG_W'(r_q_l) * K_MAG_W'(K_OUTPUT_RATE_HZ);
    assign w_qo_r = K_MAG_W'(r_q_r) * K_MAG_W'(K_OUTPUT_RATE_HZ);

    assign o_q_pop     = (r_state == BS_IDLE) && !i_q_empty;
    assign w_load_out  = (r_state == BS_FIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (!i_q_empty) n_state = BS_MUL;
            BS_MUL:  n_state = BS_DIV;
            BS_DIV:  n_state = BS_REM;
            BS_REM:  n_state = BS_FIN;
            BS_FIN:  if (w_load_out) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (r_state == BS_MUL) begin
            r_prod_l <= K_MAG_W'(w_dm_l[K_SAMPLE_W-1:0]) * K_MAG_W'(r_job.phase);
            r_prod_r <= K_MAG_W'(w_dm_r[K_SAMPLE_W-1:0]) * K_MAG_W'(r_job.phase);
            r_neg_l  <= w_dm_l[K_SAMPLE_W];
            r_neg_r  <= w_dm_r[K_SAMPLE_W];
        end
        if (r_state == BS_DIV) begin
            r_q_l <= w_recip_l[K_RECIP_SHIFT +: K_Q_W];
            r_q_r <= w_recip_r[K_RECIP_SHIFT +: K_Q_W];
        end
        if (r_state == BS_REM) begin
            r_rem_nz_l <= (r_prod_l != w_qo_l);
            r_rem_nz_r <= (r_prod_r != w_qo_r);
        end
        if (w_load_out) begin
            r_out_item.left_out    <= fix_result(r_job.prev_left, r_q_l, r_neg_l,
                                                 r_rem_nz_l);
            r_out_item.right_out   <= fix_result(r_job.prev_right, r_q_r, r_neg_r,
                                                 r_rem_nz_r);
            r_out_item.last_of_run <= r_job.last;
        end
    end

endmodule

// File: sv/stereo_linear_resampler_unit.sv
// top level of the stereo linear resampler: config register, front end, job queue, back end
//
//  channel   direction  handshake                      payload
//  input     in         i_in_valid / o_in_ready        i_in_item  (left_in, right_in)
//  output    out        o_out_valid / i_out_ready      o_out_item (left_out, right_out,
//                                                                  last_of_run)
//  config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// each output passes through the back end in order: queue pop, magnitude multiply,
// reciprocal multiply for the quotient, remainder check, rounding into the output register;
// an item makes n outputs (0 to 6); the back end pops no new job until the last one is loaded
// the front end accepts an item in its idle state, then issues one job per output while the
// queue is not full, so it runs ahead of the back end until the job queue fills
// synchronous active-low reset clears phase, stored frame, queue and output valid;
// the rate register returns to 48000
// a stalled output only stops the back end; the front keeps issuing jobs until the queue
// is full, then holds off the input
module stereo_linear_resampler_unit #(
    parameter int QUEUE_DEPTH    = slr_pkg::K_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input frames
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  slr_pkg::t_in_item              i_in_item,
    // output samples at the output rate
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output slr_pkg::t_out_item             o_out_item,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slr_pkg::K_PADDR_W-1:0]  paddr,
    input  logic [slr_pkg::K_PDATA_W-1:0]  pwdata,
    output logic [slr_pkg::K_PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import slr_pkg::*;

    // input rate register, added to the phase once per output
    logic [K_RATE_W-1:0]    r_input_rate;
    logic                   w_cfg_wr;
    logic                   w_reg_hit;

    // queue traffic between front and back
    logic                   w_q_push;
    logic                   w_q_pop;
    logic                   w_q_full;
    logic                   w_q_empty;
    t_job                   w_q_wr_job;
    t_job                   w_q_rd_job;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[2] == K_REG_INPUT_RATE);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_reg_hit ? {{(K_PDATA_W-K_RATE_W){1'b0}}, r_input_rate} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_rate <= K_RATE_RESET;
        end else if (w_cfg_wr && w_reg_hit) begin
            r_input_rate <= pwdata[K_RATE_W-1:0];
        end
    end

    // front end: phase stepping, decimation and run splitting
    slr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rate     (r_input_rate),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_job    (w_q_wr_job)
    );

    // job queue decouples the two ends
    slr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_q_push),
        .i_wr_data (w_q_wr_job),
        .i_pop     (w_q_pop),
        .o_rd_data (w_q_rd_job),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    // back end: interpolation arithmetic and output register
    slr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .i_q_job     (w_q_rd_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("job pushed into full queue");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("job popped from empty queue");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a frame is not taken while the front is still issuing jobs for the previous one
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !o_in_ready)
        else $error("front ready while issuing jobs");

endmodule
